// ----- sv/scpa_pkg.sv -----
// Shared constants, payload types and codes for the size-class pool allocator.
`timescale 1ns / 1ps
`default_nettype none
package scpa_pkg;

  // Arena geometry
  localparam int NUM_SLABS      = 16;
  localparam int SLAB_WORDS     = 8192;
  localparam int MAX_POOL_WORDS = 4;
  localparam int HEADER_WORDS   = 1;
  localparam int ARENA_WORDS    = NUM_SLABS * SLAB_WORDS;

  // Field widths
  localparam int ADDR_W = 17;
  localparam int SIZE_W = 16;

  // Internal widths
  localparam int LIM_W      = $clog2(ARENA_WORDS + 1);
  localparam int SLAB_CNT_W = $clog2(NUM_SLABS + 1);
  localparam int CLS_W      = (MAX_POOL_WORDS > 1) ? $clog2(MAX_POOL_WORDS) : 1;
  localparam int NEED_W     = $clog2(HEADER_WORDS + MAX_POOL_WORDS + 1);

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_GRANT   = 2'd0,
    ST_GENERAL = 2'd1,
    ST_OOM     = 2'd2,
    ST_POOLED  = 2'd3
  } status_t;

  typedef struct packed {
    logic              operation;
    logic [SIZE_W-1:0] size_words;
    logic [ADDR_W-1:0] free_address;
    logic              was_pooled;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    status_t           status;
  } rsp_t;

  // Free-list link: valid bit plus address of the next free block
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
  } link_t;

  // Bump unit answer for the current request
  typedef struct packed {
    logic              oom;
    logic [ADDR_W-1:0] addr;
  } bump_rsp_t;

endpackage
`default_nettype wire

// ----- sv/size_class_pool_allocator_core.sv -----
// Top level of the size-class pool allocator: request sequencer and list heads.
// Sequence: an accepted request is held and handled in S_EXEC, which registers the result and
// done; a pop from a free list passes on through S_POP for the registered link RAM read.
// A new request is not taken while one is in progress; start is taken again in the done cycle.
// Reset (rst, synchronous): free lists empty, no slab open, cursor at zero; link RAM kept.
// done is a one-cycle strobe; the receiver cannot stall a transfer.
`timescale 1ns / 1ps
`default_nettype none
module size_class_pool_allocator_core
  import scpa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t request,
  output logic      busy,
  output logic      done,
  output rsp_t      result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP
  } state_t;

  state_t state;
  req_t   req;

  // Free-list heads, small enough for flip-flops
  logic              head_valid [MAX_POOL_WORDS];
  logic [ADDR_W-1:0] head_addr  [MAX_POOL_WORDS];

  // Decode of the held request
  logic             size_ok;
  logic             addr_ok;
  logic [CLS_W-1:0] cls;
  logic             is_alloc;
  logic             do_pop;
  logic             do_bump;
  logic             do_push;

  logic              ram_we;
  logic              ram_re;
  link_t             ram_wdata;
  link_t             ram_rdata;
  bump_rsp_t         bump_rsp;
  logic [NEED_W-1:0] need;
  rsp_t              result_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    size_ok  = (req.size_words != '0) && (int'(req.size_words) <= MAX_POOL_WORDS);
    addr_ok  = (int'(req.free_address) < ARENA_WORDS);
    cls      = CLS_W'(req.size_words - SIZE_W'(1));
    is_alloc = (req.operation == OP_ALLOC);
    do_pop   = (state == S_EXEC) && is_alloc && size_ok && head_valid[cls];
    do_bump  = (state == S_EXEC) && is_alloc && size_ok && !head_valid[cls];
    do_push  = (state == S_EXEC) && !is_alloc && req.was_pooled && size_ok && addr_ok;
    need     = NEED_W'(HEADER_WORDS) + NEED_W'(req.size_words);
    // Push links the block to the old head
    ram_we          = do_push;
    ram_wdata.valid = head_valid[cls];
    ram_wdata.addr  = head_addr[cls];
    ram_re          = do_pop;
    // Result of the request finishing this cycle
    result_next.block_address = '0;
    result_next.status        = ST_GENERAL;
    if (state == S_POP) begin
      result_next.block_address = head_addr[cls];
      result_next.status        = ST_GRANT;
    end else if (do_bump) begin
      if (bump_rsp.oom) begin
        result_next.status = ST_OOM;
      end else begin
        result_next.block_address = bump_rsp.addr;
        result_next.status        = ST_GRANT;
      end
    end else if (do_push) begin
      result_next.status = ST_POOLED;
    end
  end

  scpa_link_ram u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req.free_address),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_addr[cls]),
    .rdata (ram_rdata)
  );

  scpa_bump u_bump (
    .clk    (clk),
    .rst    (rst),
    .commit (do_bump),
    .need   (need),
    .rsp    (bump_rsp)
  );

  // Sequencer, list heads and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      for (int i = 0; i < MAX_POOL_WORDS; i++) begin
        head_valid[i] <= 1'b0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            req   <= request;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (do_pop) begin
            // wait for the link of the head block
            done  <= 1'b0;
            state <= S_POP;
          end else begin
            state  <= S_IDLE;
            done   <= 1'b1;
            result <= result_next;
            if (do_push) begin
              head_valid[cls] <= 1'b1;
              head_addr[cls]  <= req.free_address;
            end
          end
        end
        S_POP: begin
          head_valid[cls] <= ram_rdata.valid;
          head_addr[cls]  <= ram_rdata.addr;
          result          <= result_next;
          done            <= 1'b1;
          state           <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/scpa_link_ram.sv -----
// Per-block free-list link memory, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module scpa_link_ram
  import scpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire link_t             wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output link_t                  rdata
);

  link_t mem [ARENA_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/scpa_bump.sv -----
// Slab opener and bump cursor: computes the next bump grant and commits it.
`timescale 1ns / 1ps
`default_nettype none
module scpa_bump
  import scpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              commit,
  input  wire logic [NEED_W-1:0] need,
  output bump_rsp_t              rsp
);

  logic [LIM_W-1:0]      cursor;
  logic [LIM_W-1:0]      limit;
  logic [SLAB_CNT_W-1:0] slabs;

  logic [LIM_W-1:0] need_ext;
  logic [LIM_W-1:0] base;
  logic [LIM_W-1:0] grant;
  logic             open_new;
  logic             oom;

  always_comb begin
    need_ext = LIM_W'(need);
    base     = LIM_W'(int'(slabs) * SLAB_WORDS);
    open_new = (slabs == '0) || (cursor > limit) || ((limit - cursor) < need_ext);
    oom      = open_new && (int'(slabs) >= NUM_SLABS);
    grant    = open_new ? (base + LIM_W'(1)) : cursor;
    rsp.oom  = oom;
    rsp.addr = grant[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      limit  <= '0;
      slabs  <= '0;
    end else if (commit && !oom) begin
      cursor <= grant + need_ext;
      if (open_new) begin
        limit <= base + LIM_W'(SLAB_WORDS);
        slabs <= slabs + SLAB_CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire
